### hw/rtl/evr_pkg.sv
// shared types and constants for the vertex euler rotation block
`timescale 1ns / 1ps
package evr_pkg;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int ANGLE_W   = 9;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  typedef logic [ANGLE_W-1:0]   angle_t;

  localparam cfg_index_t REG_ANGLE_X = 2'd0;
  localparam cfg_index_t REG_ANGLE_Y = 2'd1;
  localparam cfg_index_t REG_ANGLE_Z = 2'd2;

  // angle geometry in whole degrees
  localparam int QUARTER_ENTRIES = 91;
  localparam int QIDX_W          = 7;
  localparam angle_t DEG_QUARTER    = 9'd90;
  localparam angle_t DEG_HALF_TURN  = 9'd180;
  localparam angle_t DEG_3_QUARTERS = 9'd270;
  localparam angle_t DEG_FULL_TURN  = 9'd360;

  // register stages in one planar rotation, and input register ahead of the three rotations
  localparam int STAGE_LAT = 2;
  localparam int PIPE_LAT  = 1 + 3 * STAGE_LAT;

  // pi in Q60 and one degree in Q60
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_STEP = PI_Q60 / 64'd180;

endpackage

### hw/rtl/evr_trig.sv
// angle register with registered sine and cosine lookup from a quarter-wave table
`timescale 1ns / 1ps
module evr_trig #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  evr_pkg::angle_t              wr_data,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);
  import evr_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;

  // quarter-wave table, built at elaboration
  logic [TW-1:0] rom [QUARTER_ENTRIES];

  for (genvar g = 0; g < QUARTER_ENTRIES; g++) begin : g_rom
    // ten-term sine series in Q30 at g degrees, rounded half up to the trig fraction width
    localparam logic [63:0] RAD     = (64'(g) * PI_STEP + (64'd1 << 29)) >> 30;
    localparam logic [63:0] RAD_SQ  = (RAD * RAD + (64'd1 << 29)) >> 30;
    localparam logic [63:0] TERM1   = RAD;
    localparam logic [63:0] TERM2   = ((TERM1 * RAD_SQ) >> 30) / 64'd6;
    localparam logic [63:0] TERM3   = ((TERM2 * RAD_SQ) >> 30) / 64'd20;
    localparam logic [63:0] TERM4   = ((TERM3 * RAD_SQ) >> 30) / 64'd42;
    localparam logic [63:0] TERM5   = ((TERM4 * RAD_SQ) >> 30) / 64'd72;
    localparam logic [63:0] TERM6   = ((TERM5 * RAD_SQ) >> 30) / 64'd110;
    localparam logic [63:0] TERM7   = ((TERM6 * RAD_SQ) >> 30) / 64'd156;
    localparam logic [63:0] TERM8   = ((TERM7 * RAD_SQ) >> 30) / 64'd210;
    localparam logic [63:0] TERM9   = ((TERM8 * RAD_SQ) >> 30) / 64'd272;
    localparam logic [63:0] TERM10  = ((TERM9 * RAD_SQ) >> 30) / 64'd342;
    localparam logic [63:0] SERIES  = TERM1 - TERM2 + TERM3 - TERM4 + TERM5
                                    - TERM6 + TERM7 - TERM8 + TERM9 - TERM10;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] CLAMPED = ($signed(SERIES) < 64'sd0) ? 64'd0 :
                                      ($signed(SERIES) > $signed(ONE_Q30)) ? ONE_Q30 : SERIES;
    localparam logic [TW-1:0] ROM_VAL =
      TW'((CLAMPED + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
    assign rom[g] = ROM_VAL;
  end

  // fold an angle in 0..359 onto the first quadrant
  function automatic logic [QIDX_W:0] fold(input angle_t a);
    angle_t idx;
    logic   neg;
    if (a <= DEG_QUARTER) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= DEG_HALF_TURN) begin
      idx = DEG_HALF_TURN - a;
      neg = 1'b0;
    end else if (a <= DEG_3_QUARTERS) begin
      idx = a - DEG_HALF_TURN;
      neg = 1'b1;
    end else begin
      idx = DEG_FULL_TURN - a;
      neg = 1'b1;
    end
    return {neg, idx[QIDX_W-1:0]};
  endfunction

  angle_t angle;
  angle_t ang_mod;
  logic [ANGLE_W:0] cos_sum;
  angle_t cos_ang;
  logic [QIDX_W:0] sin_fold;
  logic [QIDX_W:0] cos_fold;
  logic signed [TW-1:0] sin_mag;
  logic signed [TW-1:0] cos_mag;
  logic signed [TW-1:0] sin_next;
  logic signed [TW-1:0] cos_next;

  // configured angle
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
    end else if (wr_en) begin
      angle <= wr_data;
    end
  end

  // reduce modulo a full turn, cosine is sine a quarter turn ahead
  always_comb begin
    ang_mod  = (angle >= DEG_FULL_TURN) ? angle - DEG_FULL_TURN : angle;
    cos_sum  = {1'b0, ang_mod} + {1'b0, DEG_QUARTER};
    cos_ang  = (cos_sum >= {1'b0, DEG_FULL_TURN}) ? ANGLE_W'(cos_sum - {1'b0, DEG_FULL_TURN})
                                                   : cos_sum[ANGLE_W-1:0];
    sin_fold = fold(ang_mod);
    cos_fold = fold(cos_ang);
    sin_mag  = $signed(rom[sin_fold[QIDX_W-1:0]]);
    cos_mag  = $signed(rom[cos_fold[QIDX_W-1:0]]);
    sin_next = sin_fold[QIDX_W] ? -sin_mag : sin_mag;
    cos_next = cos_fold[QIDX_W] ? -cos_mag : cos_mag;
  end

  // registered coefficients
  always_ff @(posedge clk) begin
    sin_val <= sin_next;
    cos_val <= cos_next;
  end

endmodule

### hw/rtl/evr_rot_stage.sv
// one planar rotation: u' = u*c + v*s, v' = v*c - u*s, rounded and saturated, third axis carried
`timescale 1ns / 1ps
module evr_rot_stage #(
  parameter int COORD_WIDTH    = 32,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [COORD_WIDTH-1:0]    in_u,
  input  logic signed [COORD_WIDTH-1:0]    in_v,
  input  logic signed [COORD_WIDTH-1:0]    in_w,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  output logic                             out_valid,
  output logic signed [COORD_WIDTH-1:0]    out_u,
  output logic signed [COORD_WIDTH-1:0]    out_v,
  output logic signed [COORD_WIDTH-1:0]    out_w
);
  import evr_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = W + TW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);

  // floor shift by the fraction bits, then clamp to the coordinate range
  function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] sh;
    logic [SW-W:0]        top;
    sh  = v >>> TRIG_FRAC_BITS;
    top = sh[SW-1:W-1];
    if ((&top) || !(|top)) return sh[W-1:0];
    return sh[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  logic signed [PW-1:0] u_ext;
  logic signed [PW-1:0] v_ext;
  logic signed [PW-1:0] c_ext;
  logic signed [PW-1:0] s_ext;

  logic                 vld1;
  logic signed [PW-1:0] p_uc;
  logic signed [PW-1:0] p_vs;
  logic signed [PW-1:0] p_vc;
  logic signed [PW-1:0] p_us;
  logic signed [W-1:0]  w1;

  logic signed [SW-1:0] sum_u;
  logic signed [SW-1:0] sum_v;

  assign u_ext = PW'(in_u);
  assign v_ext = PW'(in_v);
  assign c_ext = PW'(cos_val);
  assign s_ext = PW'(sin_val);

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_uc <= u_ext * c_ext;
    p_vs <= v_ext * s_ext;
    p_vc <= v_ext * c_ext;
    p_us <= u_ext * s_ext;
    w1   <= in_w;
  end

  // combine, round half up, saturate
  assign sum_u = SW'(p_uc) + SW'(p_vs) + HALF;
  assign sum_v = SW'(p_vc) - SW'(p_us) + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    out_u <= sat(sum_u);
    out_v <= sat(sum_v);
    out_w <= w1;
  end

endmodule

### hw/rtl/vertex_euler_rotation_top.sv
// top level: x, y, z euler rotation of a fixed-point vertex stream
`timescale 1ns / 1ps
//  channel  | signals                            | transfer rule
//  ---------+------------------------------------+----------------------------------
//  vertex   | start, busy, in_x, in_y, in_z      | start high and busy low at edge
//  result   | done, out_x, out_y, out_z          | done high for one cycle, no stall
//  config   | cfg_valid, cfg_ready, cfg_index,   | cfg_valid and cfg_ready high
//           | cfg_data                           |
//
// one vertex can be taken every cycle while busy is low; its result reaches the ports
// through an input register plus two stages (multiply, then round and saturate) per axis.
// busy is high through reset and in the first cycle after it; cfg_ready is always high.
// reset clears the angles to zero and empties the pipeline.
// angles are to be written only with no vertex in flight; the block does not enforce this.
// a write passes through the angle register and then the registered coefficients.
module vertex_euler_rotation_top #(
  parameter int COORD_WIDTH    = 32,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  evr_pkg::cfg_index_t           cfg_index,
  input  evr_pkg::angle_t               cfg_data
);
  import evr_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int TW = TRIG_FRAC_BITS + 2;

  logic in_fire;
  logic cfg_fire;

  logic                vld0;
  logic signed [W-1:0] x0;
  logic signed [W-1:0] y0;
  logic signed [W-1:0] z0;

  logic signed [TW-1:0] sin_x;
  logic signed [TW-1:0] cos_x;
  logic signed [TW-1:0] sin_y;
  logic signed [TW-1:0] cos_y;
  logic signed [TW-1:0] sin_y_neg;
  logic signed [TW-1:0] sin_z;
  logic signed [TW-1:0] cos_z;

  logic                vld_x;
  logic signed [W-1:0] x_y;
  logic signed [W-1:0] x_z;
  logic signed [W-1:0] x_x;
  logic                vld_y;
  logic signed [W-1:0] y_x;
  logic signed [W-1:0] y_z;
  logic signed [W-1:0] y_y;

  assign in_fire   = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // hold off the vertex channel for the cycle after reset while coefficients settle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // angle registers and coefficient lookup, one per axis
  evr_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_x (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_fire && (cfg_index == REG_ANGLE_X)),
    .wr_data (cfg_data),
    .sin_val (sin_x),
    .cos_val (cos_x)
  );

  evr_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_y (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_fire && (cfg_index == REG_ANGLE_Y)),
    .wr_data (cfg_data),
    .sin_val (sin_y),
    .cos_val (cos_y)
  );

  evr_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_z (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_fire && (cfg_index == REG_ANGLE_Z)),
    .wr_data (cfg_data),
    .sin_val (sin_z),
    .cos_val (cos_z)
  );

  // y rotation runs the same form with the sine negated
  assign sin_y_neg = -sin_y;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    x0 <= in_x;
    y0 <= in_y;
    z0 <= in_z;
  end

  // rotation about x: (y, z) turn, x carried
  evr_rot_stage #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld0),
    .in_u      (y0),
    .in_v      (z0),
    .in_w      (x0),
    .cos_val   (cos_x),
    .sin_val   (sin_x),
    .out_valid (vld_x),
    .out_u     (x_y),
    .out_v     (x_z),
    .out_w     (x_x)
  );

  // rotation about y: (x, z) turn, y carried
  evr_rot_stage #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_x),
    .in_u      (x_x),
    .in_v      (x_z),
    .in_w      (x_y),
    .cos_val   (cos_y),
    .sin_val   (sin_y_neg),
    .out_valid (vld_y),
    .out_u     (y_x),
    .out_v     (y_z),
    .out_w     (y_y)
  );

  // rotation about z: (x, y) turn, z carried, registers drive the result ports
  evr_rot_stage #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_y),
    .in_u      (y_x),
    .in_v      (y_y),
    .in_w      (y_z),
    .cos_val   (cos_z),
    .sin_val   (sin_z),
    .out_valid (done),
    .out_u     (out_x),
    .out_v     (out_y),
    .out_w     (out_z)
  );

`ifndef SYNTHESIS
  // every accepted vertex comes out after the fixed pipeline latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    in_fire |-> ##PIPE_LAT done)
    else $error("accepted vertex did not produce a result on time");

  // no result without a vertex accepted the pipeline latency earlier
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_fire, PIPE_LAT))
    else $error("result strobe without a matching accepted vertex");

  // pipeline is empty right after reset
  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !vld0 && !vld_x && !vld_y && !done)
    else $error("pipeline not cleared by reset");
`endif

endmodule

### bench/evr_checker.sv
`timescale 1ns / 1ps
// checker for the euler rotation block: tracks angles, predicts each vertex, compares results
module evr_checker #(
  parameter int COORD_W   = 32,
  parameter int TRIG_FRAC = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic signed [COORD_W-1:0] in_z,
  input  logic                      done,
  input  logic signed [COORD_W-1:0] out_x,
  input  logic signed [COORD_W-1:0] out_y,
  input  logic signed [COORD_W-1:0] out_z,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  evr_pkg::cfg_index_t       cfg_index,
  input  evr_pkg::angle_t           cfg_data,
  output int                        mismatches,
  output int                        compared,
  output int                        outstanding
);
  import evr_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_DEG_Q60 = PI_Q60 / 64'd180;
  localparam coord_t      COORD_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t      COORD_MIN   = {1'b1, {(COORD_W-1){1'b0}}};

  // angle registers as the block should hold them
  angle_t ang_x = '0;
  angle_t ang_y = '0;
  angle_t ang_z = '0;

  // rotated vertices still on their way through the pipeline
  vertex_t rotated_q[$];

  // sin of 0..90 degrees: series in Q30, rounded half up to the trig fraction width
  function automatic int quarter_sine(int unsigned deg);
    logic [63:0] rad;
    logic [63:0] rad_sq;
    logic [63:0] term;
    longint      acc;
    rad    = (64'(deg) * ONE_DEG_Q60 + (64'd1 << 29)) >> 30;
    rad_sq = (rad * rad + (64'd1 << 29)) >> 30;
    term   = rad;
    acc    = 0;
    for (int k = 1; k <= 10; k++) begin
      if (k % 2 == 1) acc += longint'(term);
      else acc -= longint'(term);
      term = ((term * rad_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
    return int'((acc + (longint'(1) << (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC));
  endfunction

  // full-circle sine by folding into the first quadrant
  function automatic int sine_of(int unsigned deg);
    if (deg <= 90) return quarter_sine(deg);
    if (deg <= 180) return quarter_sine(180 - deg);
    if (deg <= 270) return -quarter_sine(deg - 180);
    return -quarter_sine(360 - deg);
  endfunction

  // register value reduced mod 360, cosine as sine a quarter turn ahead
  function automatic void trig_pair(input angle_t raw, output int s, output int c);
    int unsigned a;
    a = int'(raw) % 360;
    s = sine_of(a);
    c = sine_of((a + 90) % 360);
  endfunction

  // a*p + b*q rounded half up at the trig point, then saturated
  function automatic coord_t mix(coord_t a, int p, coord_t b, int q);
    longint acc;
    acc = longint'(a) * p + longint'(b) * q + (longint'(1) << (TRIG_FRAC - 1));
    acc = acc >>> TRIG_FRAC;
    if (acc > longint'(COORD_MAX)) return COORD_MAX;
    if (acc < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(acc);
  endfunction

  // x, then y, then z rotation of a row vector
  function automatic vertex_t rotate_vertex(vertex_t v, angle_t ax, angle_t ay, angle_t az);
    int      s;
    int      c;
    vertex_t r;
    r = v;
    trig_pair(ax, s, c);
    r.y = mix(v.y, c, v.z, s);
    r.z = mix(v.z, c, v.y, -s);
    v = r;
    trig_pair(ay, s, c);
    r.x = mix(v.x, c, v.z, -s);
    r.z = mix(v.x, s, v.z, c);
    v = r;
    trig_pair(az, s, c);
    r.x = mix(v.x, c, v.y, s);
    r.y = mix(v.y, c, v.x, -s);
    return r;
  endfunction

  task automatic check_axis(string axis, coord_t want, coord_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", axis, want, got);
      mismatches++;
    end
  endtask

  // watch all three channels at each edge; results first so a fresh vertex never matches
  always @(posedge clk) begin : watch
    vertex_t want;
    vertex_t taken;
    if (rst) begin
      rotated_q.delete();
      ang_x = '0;
      ang_y = '0;
      ang_z = '0;
    end else begin
      // result transaction
      if (done) begin
        if (rotated_q.size() == 0) begin
          $error("result with no vertex pending: x %0d y %0d z %0d", out_x, out_y, out_z);
          mismatches++;
        end else begin
          want = rotated_q.pop_front();
          check_axis("out_x", want.x, out_x);
          check_axis("out_y", want.y, out_y);
          check_axis("out_z", want.z, out_z);
          compared++;
        end
      end
      // vertex transaction uses the angles in force before this edge
      if (start && !busy) begin
        taken.x = in_x;
        taken.y = in_y;
        taken.z = in_z;
        rotated_q.insert(rotated_q.size(), rotate_vertex(taken, ang_x, ang_y, ang_z));
      end
      // register write transaction; unused index is dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ANGLE_X: ang_x = cfg_data;
          REG_ANGLE_Y: ang_y = cfg_data;
          REG_ANGLE_Z: ang_z = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= rotated_q.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// testbench top: drives vertices and angle writes into the euler rotation block
module tb_top;
  import evr_pkg::*;

  localparam int         COORD_W         = 32;
  localparam int         TRIG_FRAC       = 14;
  localparam int         VERTS_PER_PHASE = 50;
  localparam int         RANDOM_PHASES   = 12;
  localparam int         CYCLE_LIMIT     = 200000;
  localparam cfg_index_t REG_SPARE       = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  coord_t     in_x      = '0;
  coord_t     in_y      = '0;
  coord_t     in_z      = '0;
  logic       cfg_valid = 1'b0;
  cfg_index_t cfg_index = REG_ANGLE_X;
  angle_t     cfg_data  = '0;

  logic   busy;
  logic   done;
  logic   cfg_ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;

  int mismatches;
  int compared;
  int outstanding;
  int cycles   = 0;
  int sent     = 0;
  int settings = 1;

  // directed vertices: zero, extremes, units and lsb-level values
  coord_t dir_x[8] = '{32'sd0, C_MAX, C_MIN, C_MAX, 32'sh0001_0000, 32'sd0, 32'sd1,
                       32'sh7FFF_0000};
  coord_t dir_y[8] = '{32'sd0, C_MAX, C_MIN, C_MIN, 32'sd0, -32'sh0001_0000, -32'sd1,
                       -32'sh0000_8000};
  coord_t dir_z[8] = '{32'sd0, C_MAX, C_MIN, C_MAX, 32'sd0, 32'sh0000_8000, 32'sd1,
                       32'sd123456};
  angle_t quadrant_bounds[8] = '{9'd0, 9'd90, 9'd91, 9'd180, 9'd181, 9'd270, 9'd271, 9'd359};

  vertex_euler_rotation_top #(
    .COORD_WIDTH   (COORD_W),
    .TRIG_FRAC_BITS(TRIG_FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .done     (done),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  evr_checker #(
    .COORD_W  (COORD_W),
    .TRIG_FRAC(TRIG_FRAC)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .done       (done),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .compared   (compared),
    .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  // reset asserted from time zero, then released
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // full-range words mixed with smaller magnitudes and the rails
  function automatic coord_t rand_coord();
    coord_t raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2, 3, 4: return raw >>> 12;
      5, 6: return raw >>> 4;
      default: return raw;
    endcase
  endfunction

  // quadrant boundaries, then unreduced values up to 511, then the normal range
  function automatic angle_t rand_angle();
    case ($urandom_range(0, 9))
      0: return quadrant_bounds[$urandom_range(0, 7)];
      1, 2: return angle_t'($urandom_range(0, 511));
      default: return angle_t'($urandom_range(0, 359));
    endcase
  endfunction

  // vertex transaction; start stays high for a following vertex
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z);
    start <= 1'b1;
    in_x  <= x;
    in_y  <= y;
    in_z  <= z;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every pending result is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // write all three angles plus a junk write to the unused index
  task automatic configure(input angle_t ax, input angle_t ay, input angle_t az);
    cfg_index_t idx[4];
    angle_t     val[4];
    idx = '{REG_ANGLE_X, REG_SPARE, REG_ANGLE_Y, REG_ANGLE_Z};
    val = '{ax, angle_t'($urandom), ay, az};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    bit burst;
    do @(posedge clk); while (rst);

    // directed vertices at reset angles, a saturating setting, then wrapped angles
    for (int s = 0; s < 3; s++) begin
      if (s == 1) configure(9'd45, 9'd135, 9'd315);
      if (s == 2) configure(9'd359, 9'd360, 9'd511);
      for (int i = 0; i < 8; i++) begin
        send_vertex(dir_x[i], dir_y[i], dir_z[i]);
        idle(i % 2);
      end
      drain();
    end

    // random phases: angle extremes first, then random angles
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(9'd0, 9'd0, 9'd0);
        1: configure(9'd359, 9'd359, 9'd359);
        2: configure(9'd511, 9'd511, 9'd511);
        3: configure(9'd90, 9'd180, 9'd270);
        default: configure(rand_angle(), rand_angle(), rand_angle());
      endcase
      burst = (p % 4 == 1) || ($urandom_range(0, 4) == 0);
      for (int i = 0; i < VERTS_PER_PHASE; i++) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord());
        if (!burst) idle(gap_len());
        // one pause mid-stream until the pipeline is empty
        if (p == RANDOM_PHASES / 2 && i == VERTS_PER_PHASE / 2) drain();
      end
      drain();
    end

    repeat (PIPE_LAT + 4) @(posedge clk);
    $display("tb_top: %0d vertices sent under %0d angle settings, %0d results compared",
             sent, settings, compared);
    $display("tb_top: angles covered reset, quadrant edges, values past 359 and saturation");
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/evr_pkg.sv
hw/rtl/evr_trig.sv
hw/rtl/evr_rot_stage.sv
hw/rtl/vertex_euler_rotation_top.sv
bench/evr_checker.sv
bench/tb_top.sv
